### sv/ray_sphere_plane_intersect_macros.svh
// Assertion macros for the ray intersection RTL.
`ifndef RAY_SPHERE_PLANE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_PLANE_INTERSECT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rspi_pkg.sv
// Package with widths, codes and types of the ray intersection pipeline.
`timescale 1ns / 1ps
package rspi_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned SumW     = 66;
  localparam int unsigned SqW      = 128;
  localparam int unsigned RootW    = 64;
  localparam int unsigned RemW     = 68;
  localparam int unsigned MagW     = 65;
  localparam int unsigned QuoW     = 32;
  localparam int unsigned SqSteps  = RootW;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned EpsW     = 16;
  localparam logic [EpsW-1:0] EpsReset = 16'd7;

  typedef enum logic {
    KIND_SPHERE = 1'b0,
    KIND_PLANE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    HITS_NONE   = 2'd0,
    HITS_PLANE  = 2'd1,
    HITS_SPHERE = 2'd2
  } hits_e;

  // Per-ray data carried alongside the discriminant and the root.
  typedef struct packed {
    kind_e              kind;
    logic               ok;
    logic               neg;
    logic [ProdW-1:0]   bm;
    logic [ProdW-1:0]   dd;
  } side_t;

  // One restoring divider lane.
  typedef struct packed {
    logic [ProdW-1:0] rem;
    logic [QuoW-1:0]  low;
    logic [QuoW-1:0]  quo;
    logic             big;
    logic             neg;
  } div_lane_t;

endpackage

### sv/ray_sphere_plane_intersect.sv
// Top level: pipelined ray intersection against a unit sphere or the xz plane.
//
//  channel   direction  handshake              payload
//  in        input      in_valid_i / in_stall_o  object_kind, origin_*, dir_*
//  out       output     out_valid_o / out_stall_i  hit_count, t_first, t_second
//  cfg       input      cfg_we_i                 cfg_wdata_i (parallel_epsilon)
//
// One ray is taken per cycle unless a waiting result is stalled at the output.
// The pipeline holds the 64 root stages and the 32 quotient stages per divider.
// Reset clears the valid bits of every stage and loads parallel_epsilon with 7.
// A stalled output freezes the whole pipeline in place, so nothing is lost or repeated.
`timescale 1ns / 1ps
`include "ray_sphere_plane_intersect_macros.svh"
module ray_sphere_plane_intersect import rspi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [EpsW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     object_kind_i,
  input  logic signed [CoordW-1:0] origin_x_i,
  input  logic signed [CoordW-1:0] origin_y_i,
  input  logic signed [CoordW-1:0] origin_z_i,
  input  logic signed [CoordW-1:0] dir_x_i,
  input  logic signed [CoordW-1:0] dir_y_i,
  input  logic signed [CoordW-1:0] dir_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               hit_count_o,
  output logic signed [CoordW-1:0] t_first_o,
  output logic signed [CoordW-1:0] t_second_o
);

  function automatic div_lane_t div_step(div_lane_t l, logic [ProdW-1:0] dd);
    logic [ProdW:0] sh;
    logic [ProdW:0] df;
    logic           ge;
    div_lane_t      r;
    sh    = {l.rem, l.low[QuoW-1]};
    df    = sh - {1'b0, dd};
    ge    = sh >= {1'b0, dd};
    r     = l;
    r.rem = ge ? df[ProdW-1:0] : sh[ProdW-1:0];
    r.low = {l.low[QuoW-2:0], 1'b0};
    r.quo = {l.quo[QuoW-2:0], ge};
    return r;
  endfunction

  function automatic logic [QuoW-1:0] sat_t(div_lane_t l);
    logic [QuoW-1:0] r;
    if (!l.neg) begin
      r = (l.big || l.quo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : l.quo;
    end else begin
      r = (l.big || l.quo > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - l.quo);
    end
    return r;
  endfunction

  logic            adv;
  logic            out_valid_q;
  logic [EpsW-1:0] eps_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // Stage 1: all 32x32 products and the plane terms.
  logic signed [CoordW-1:0] org [3];
  logic signed [CoordW-1:0] dir [3];
  logic [CoordW-1:0]        ady, aoy;
  logic                     pl_ok_d;

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;
  assign ady    = dir_y_i[CoordW-1] ? (~dir_y_i + 32'd1) : dir_y_i;
  assign aoy    = origin_y_i[CoordW-1] ? (~origin_y_i + 32'd1) : origin_y_i;
  assign pl_ok_d = (ady != 32'd0) && (ady >= {16'd0, eps_q});

  logic                    s1_vld_q;
  kind_e                   s1_kind_q;
  logic signed [ProdW-1:0] s1_pod_q [3];
  logic        [ProdW-1:0] s1_pdd_q [3];
  logic        [ProdW-1:0] s1_poo_q [3];
  logic                    s1_plok_q, s1_plneg_q;
  logic [CoordW-1:0]       s1_plnum_q, s1_plden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q  <= kind_e'(object_kind_i);
      for (int i = 0; i < 3; i++) begin
        s1_pod_q[i] <= org[i] * dir[i];
        s1_pdd_q[i] <= ProdW'(dir[i] * dir[i]);
        s1_poo_q[i] <= ProdW'(org[i] * org[i]);
      end
      s1_plok_q  <= pl_ok_d;
      s1_plneg_q <= (origin_y_i[CoordW-1] == dir_y_i[CoordW-1]);
      s1_plnum_q <= aoy;
      s1_plden_q <= ady;
    end
  end

  // Stage 2: dot products.
  logic                   s2_vld_q;
  kind_e                  s2_kind_q;
  logic                   s2_plok_q, s2_plneg_q;
  logic [CoordW-1:0]      s2_plnum_q, s2_plden_q;
  logic [ProdW-1:0]       s2_dd_q, s2_oo_q;
  logic signed [SumW-1:0] s2_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_kind_q  <= s1_kind_q;
      s2_plok_q  <= s1_plok_q;
      s2_plneg_q <= s1_plneg_q;
      s2_plnum_q <= s1_plnum_q;
      s2_plden_q <= s1_plden_q;
      s2_dd_q    <= s1_pdd_q[0] + s1_pdd_q[1] + s1_pdd_q[2];
      s2_oo_q    <= s1_poo_q[0] + s1_poo_q[1] + s1_poo_q[2];
      s2_b_q     <= SumW'(s1_pod_q[0]) + SumW'(s1_pod_q[1]) + SumW'(s1_pod_q[2]);
    end
  end

  // Stage 3: magnitude of B; the plane ray takes over the same fields.
  logic [SumW-1:0] b_abs;
  side_t           s3_side_d, s3_side_q;
  logic            s3_vld_q;
  logic [ProdW-1:0] s3_oo_q;

  assign b_abs = s2_b_q[SumW-1] ? (SumW'(0) - s2_b_q) : s2_b_q;

  always_comb begin
    s3_side_d.kind = s2_kind_q;
    if (s2_kind_q == KIND_PLANE) begin
      s3_side_d.ok  = s2_plok_q;
      s3_side_d.neg = s2_plneg_q;
      s3_side_d.bm  = {32'd0, s2_plnum_q};
      s3_side_d.dd  = {32'd0, s2_plden_q};
    end else begin
      s3_side_d.ok  = (s2_dd_q != '0);
      s3_side_d.neg = !s2_b_q[SumW-1] && (s2_b_q != '0);
      s3_side_d.bm  = b_abs[ProdW-1:0];
      s3_side_d.dd  = s2_dd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_side_q <= s3_side_d;
      s3_oo_q   <= s2_oo_q;
    end
  end

  // Stage 4: 32x32 partial products of B*B and DD*OO.
  logic             s4_vld_q;
  side_t            s4_side_q;
  logic [ProdW-1:0] s4_a00_q, s4_a01_q, s4_a11_q;
  logic [ProdW-1:0] s4_p00_q, s4_p01_q, s4_p10_q, s4_p11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_side_q <= s3_side_q;
      s4_a00_q  <= s3_side_q.bm[31:0]  * s3_side_q.bm[31:0];
      s4_a01_q  <= s3_side_q.bm[31:0]  * s3_side_q.bm[63:32];
      s4_a11_q  <= s3_side_q.bm[63:32] * s3_side_q.bm[63:32];
      s4_p00_q  <= s3_side_q.dd[31:0]  * s3_oo_q[31:0];
      s4_p01_q  <= s3_side_q.dd[31:0]  * s3_oo_q[63:32];
      s4_p10_q  <= s3_side_q.dd[63:32] * s3_oo_q[31:0];
      s4_p11_q  <= s3_side_q.dd[63:32] * s3_oo_q[63:32];
    end
  end

  // Stage 5: B*B + DD*2^32 and DD*OO as full 128-bit values.
  logic           s5_vld_q;
  side_t          s5_side_q;
  logic [SqW-1:0] s5_lhs_q, s5_rhs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (adv) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_side_q <= s4_side_q;
      s5_lhs_q  <= {s4_a11_q, 64'd0} + {31'd0, s4_a01_q, 33'd0} + {64'd0, s4_a00_q}
                 + {32'd0, s4_side_q.dd, 32'd0};
      s5_rhs_q  <= {s4_p11_q, 64'd0} + {32'd0, s4_p01_q, 32'd0}
                 + {32'd0, s4_p10_q, 32'd0} + {64'd0, s4_p00_q};
    end
  end

  // Stage 6: discriminant; a negative one makes a sphere ray a miss. Feeds root stage 0.
  logic [SqW:0] disc;
  side_t        s6_side_d;

  assign disc = {1'b0, s5_lhs_q} - {1'b0, s5_rhs_q};

  always_comb begin
    s6_side_d = s5_side_q;
    if (s5_side_q.kind == KIND_SPHERE) begin
      s6_side_d.ok = s5_side_q.ok && !disc[SqW];
    end
  end

  logic [SqSteps:0] sq_vld_q;
  logic [RemW-1:0]  sq_rem_q  [SqSteps+1];
  logic [RootW-1:0] sq_root_q [SqSteps+1];
  logic [SqW-1:0]   sq_x_q    [SqSteps+1];
  side_t            sq_side_q [SqSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_q[0] <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_x_q[0]    <= disc[SqW] ? '0 : disc[SqW-1:0];
      sq_side_q[0] <= s6_side_d;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic [RemW-1:0] rem_sh, trial, rem_df;
    logic            ge;

    assign rem_sh = {sq_rem_q[k][RemW-3:0], sq_x_q[k][SqW-1 -: 2]};
    assign trial  = {2'b00, sq_root_q[k], 2'b01};
    assign ge     = rem_sh >= trial;
    assign rem_df = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k+1]  <= ge ? rem_df : rem_sh;
        sq_root_q[k+1] <= {sq_root_q[k][RootW-2:0], ge};
        sq_x_q[k+1]    <= {sq_x_q[k][SqW-3:0], 2'b00};
        sq_side_q[k+1] <= sq_side_q[k];
      end
    end
  end

  // Near and far numerators as sign and magnitude.
  side_t            rt_side;
  logic [RootW-1:0] rt_s;
  logic [MagW-1:0]  sum_bs, dlt_bs, dlt_sb;
  logic             bm_lt;
  logic [MagW-1:0]  na_nmag_d, na_fmag_d;
  logic             na_nneg_d, na_fneg_d;
  hits_e            na_hits_d;

  assign rt_side = sq_side_q[SqSteps];
  assign rt_s    = sq_root_q[SqSteps];
  assign sum_bs  = {1'b0, rt_side.bm} + {1'b0, rt_s};
  assign dlt_bs  = {1'b0, rt_side.bm} - {1'b0, rt_s};
  assign dlt_sb  = {1'b0, rt_s} - {1'b0, rt_side.bm};
  assign bm_lt   = dlt_bs[MagW-1];

  always_comb begin
    na_hits_d = HITS_NONE;
    if (rt_side.ok) begin
      na_hits_d = (rt_side.kind == KIND_PLANE) ? HITS_PLANE : HITS_SPHERE;
    end
    if (rt_side.kind == KIND_PLANE) begin
      na_nmag_d = {1'b0, rt_side.bm};
      na_nneg_d = rt_side.neg;
      na_fmag_d = '0;
      na_fneg_d = 1'b0;
    end else if (rt_side.neg) begin
      // -B is negative: near moves further down, far is S - |B|.
      na_nmag_d = sum_bs;
      na_nneg_d = 1'b1;
      na_fmag_d = bm_lt ? dlt_sb : dlt_bs;
      na_fneg_d = !bm_lt;
    end else begin
      na_nmag_d = bm_lt ? dlt_sb : dlt_bs;
      na_nneg_d = bm_lt;
      na_fmag_d = sum_bs;
      na_fneg_d = 1'b0;
    end
  end

  logic             na_vld_q;
  hits_e            na_hits_q;
  logic [ProdW-1:0] na_dd_q;
  logic [MagW-1:0]  na_nmag_q, na_fmag_q;
  logic             na_nneg_q, na_fneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      na_vld_q <= 1'b0;
    end else if (adv) begin
      na_vld_q <= sq_vld_q[SqSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      na_hits_q <= na_hits_d;
      na_dd_q   <= rt_side.dd;
      na_nmag_q <= na_nmag_d;
      na_fmag_q <= na_fmag_d;
      na_nneg_q <= na_nneg_d;
      na_fneg_q <= na_fneg_d;
    end
  end

  // Divider set-up: the numerator is magnitude * 2^16; a quotient of 2^32 or more
  // is caught here by comparing the upper numerator bits with the divisor.
  div_lane_t dv_n_d, dv_f_d;

  always_comb begin
    dv_n_d.rem = {15'd0, na_nmag_q[MagW-1:16]};
    dv_n_d.low = {na_nmag_q[15:0], 16'd0};
    dv_n_d.quo = '0;
    dv_n_d.big = {15'd0, na_nmag_q[MagW-1:16]} >= na_dd_q;
    dv_n_d.neg = na_nneg_q;
    dv_f_d.rem = {15'd0, na_fmag_q[MagW-1:16]};
    dv_f_d.low = {na_fmag_q[15:0], 16'd0};
    dv_f_d.quo = '0;
    dv_f_d.big = {15'd0, na_fmag_q[MagW-1:16]} >= na_dd_q;
    dv_f_d.neg = na_fneg_q;
  end

  logic [DivSteps:0] dv_vld_q;
  div_lane_t         dv_n_q    [DivSteps+1];
  div_lane_t         dv_f_q    [DivSteps+1];
  logic [ProdW-1:0]  dv_dd_q   [DivSteps+1];
  hits_e             dv_hits_q [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= na_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_n_q[0]    <= dv_n_d;
      dv_f_q[0]    <= dv_f_d;
      dv_dd_q[0]   <= na_dd_q;
      dv_hits_q[0] <= na_hits_q;
    end
  end

  // Restoring division, one quotient bit per stage for both lanes.
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_n_q[j+1]    <= div_step(dv_n_q[j], dv_dd_q[j]);
        dv_f_q[j+1]    <= div_step(dv_f_q[j], dv_dd_q[j]);
        dv_dd_q[j+1]   <= dv_dd_q[j];
        dv_hits_q[j+1] <= dv_hits_q[j];
      end
    end
  end

  // Output register: saturation and zeroing of unused results.
  hits_e           out_hits_q;
  logic [QuoW-1:0] out_t1_q, out_t2_q;
  hits_e           fin_hits;

  assign fin_hits = dv_hits_q[DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_hits_q <= fin_hits;
      out_t1_q   <= (fin_hits != HITS_NONE) ? sat_t(dv_n_q[DivSteps]) : '0;
      out_t2_q   <= (fin_hits == HITS_SPHERE) ? sat_t(dv_f_q[DivSteps]) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_count_o = out_hits_q;
  assign t_first_o   = out_t1_q;
  assign t_second_o  = out_t2_q;

  `RSPI_ASSERT_NOW(a_miss_zero, out_valid_o && (hit_count_o == HITS_NONE), (t_first_o == '0) && (t_second_o == '0), "miss result carries a non-zero t")
  `RSPI_ASSERT_NOW(a_plane_second, out_valid_o && (hit_count_o == HITS_PLANE), t_second_o == '0, "plane result carries a far t")
  `RSPI_ASSERT_NOW(a_stall_held, in_stall_o, out_valid_o && out_stall_i, "pipeline frozen without a waiting result")
  `RSPI_ASSERT_NEXT(a_freeze, in_stall_o, out_valid_o, "waiting result dropped during a freeze")

endmodule

### sim/ray_sphere_plane_intersect_test.sv
// Self-checking testbench for the ray intersection pipeline against a sphere and a plane.
`timescale 1ns / 1ps
module ray_sphere_plane_intersect_test import rspi_pkg::*;;

  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned ItemsPerPhase = 320;
  localparam logic signed [131:0] TMax = 132'sd2147483647;
  localparam logic signed [131:0] TMin = -132'sd2147483648;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    hits_e       hits;
    logic [31:0] t_near, t_far;
  } hit_t;

  typedef struct packed {
    ray_t ray;
    logic typed;
    hit_t want;
  } row_t;

  localparam row_t DirTab [18] = '{
    '{'{KIND_SPHERE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{HITS_NONE, 32'h0, 32'h0}},
    '{'{KIND_SPHERE, 32'h0, 32'h0, 32'hFFFE0000, 32'h0, 32'h0, 32'h10000}, 1'b1,
      '{HITS_SPHERE, 32'h10000, 32'h30000}},
    '{'{KIND_SPHERE, 32'h0, 32'h20000, 32'hFFFE0000, 32'h0, 32'h0, 32'h10000}, 1'b1,
      '{HITS_NONE, 32'h0, 32'h0}},
    '{'{KIND_SPHERE, 32'h0, 32'h10000, 32'hFFFE0000, 32'h0, 32'h0, 32'h10000}, 1'b1,
      '{HITS_SPHERE, 32'h20000, 32'h20000}},
    '{'{KIND_SPHERE, 32'h0, 32'h0, 32'hFFFE0000, 32'h0, 32'h0, 32'h1}, 1'b1,
      '{HITS_SPHERE, 32'h7FFFFFFF, 32'h7FFFFFFF}},
    '{'{KIND_SPHERE, 32'h0, 32'h0, 32'h20000, 32'h0, 32'h0, 32'h1}, 1'b1,
      '{HITS_SPHERE, 32'h80000000, 32'h80000000}},
    '{'{KIND_PLANE, 32'h0, 32'h10000, 32'h0, 32'h0, 32'hFFFF0000, 32'h0}, 1'b1,
      '{HITS_PLANE, 32'h10000, 32'h0}},
    '{'{KIND_PLANE, 32'h5, 32'h10000, 32'h9, 32'h3, 32'h0, 32'h4}, 1'b1,
      '{HITS_NONE, 32'h0, 32'h0}},
    '{'{KIND_PLANE, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h6, 32'h0}, 1'b1,
      '{HITS_NONE, 32'h0, 32'h0}},
    '{'{KIND_PLANE, 32'h0, 32'h7, 32'h0, 32'h0, 32'h7, 32'h0}, 1'b1,
      '{HITS_PLANE, 32'hFFFF0000, 32'h0}},
    '{'{KIND_PLANE, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'hFFFFFFF9, 32'h0}, 1'b1,
      '{HITS_PLANE, 32'h7FFFFFFF, 32'h0}},
    '{'{KIND_PLANE, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h7, 32'h0}, 1'b1,
      '{HITS_PLANE, 32'h80000000, 32'h0}},
    '{'{KIND_SPHERE, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0}, 1'b1,
      '{HITS_SPHERE, 32'hFFFF0000, 32'h10000}},
    '{'{KIND_PLANE, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
        32'h80000000, 32'h80000000}, 1'b0, '{HITS_NONE, 32'h0, 32'h0}},
    '{'{KIND_SPHERE, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
        32'h80000000, 32'h80000000}, 1'b0, '{HITS_NONE, 32'h0, 32'h0}},
    '{'{KIND_SPHERE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
        32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, '{HITS_NONE, 32'h0, 32'h0}},
    '{'{KIND_SPHERE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
        32'h7FFFFFFF, 32'h80000000}, 1'b0, '{HITS_NONE, 32'h0, 32'h0}},
    '{'{KIND_PLANE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '{HITS_NONE, 32'h0, 32'h0}}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [EpsW-1:0]          cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     object_kind_i = 1'b0;
  logic signed [CoordW-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [CoordW-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [1:0]               hit_count_o;
  logic signed [CoordW-1:0] t_first_o, t_second_o;

  row_t            ray_feed [$];
  hit_t            hits_due [$];
  logic [EpsW-1:0] eps_now = EpsReset;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     fails = 0;
  int unsigned     quiet_cycles = 0;

  ray_sphere_plane_intersect dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .object_kind_i,
    .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .out_valid_o, .out_stall_i, .hit_count_o, .t_first_o, .t_second_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] clamp_t(logic signed [131:0] v);
    if (v > TMax) return 32'h7FFFFFFF;
    if (v < TMin) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [131:0] floor_root(logic signed [131:0] x);
    logic signed [131:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (132'sd1 <<< b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  // Exact integer intersection of one ray, with the current plane threshold.
  function automatic hit_t intersect_ray(ray_t r, logic [EpsW-1:0] eps);
    logic signed [131:0] ox, oy, oz, dx, dy, dz, dd, oo, bb, disc, root, ady;
    hit_t h;
    h = '{HITS_NONE, 32'h0, 32'h0};
    ox = $signed(r.ox); oy = $signed(r.oy); oz = $signed(r.oz);
    dx = $signed(r.dx); dy = $signed(r.dy); dz = $signed(r.dz);
    if (r.kind == KIND_SPHERE) begin
      dd = dx * dx + dy * dy + dz * dz;
      oo = ox * ox + oy * oy + oz * oz;
      bb = ox * dx + oy * dy + oz * dz;
      if (dd == 0) return h;
      disc = bb * bb + (dd <<< 32) - dd * oo;
      if (disc < 0) return h;
      root = floor_root(disc);
      h.hits = HITS_SPHERE;
      h.t_near = clamp_t(((-bb - root) <<< 16) / dd);
      h.t_far = clamp_t(((-bb + root) <<< 16) / dd);
    end else begin
      ady = (dy < 0) ? -dy : dy;
      if (ady == 0 || ady < $signed({116'd0, eps})) return h;
      h.hits = HITS_PLANE;
      h.t_near = clamp_t(((-oy) <<< 16) / dy);
    end
    return h;
  endfunction

  function automatic logic [31:0] spread(int unsigned m);
    return $urandom_range(0, 2 * m) - m;
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 4))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h0;
      3: return 32'h1;
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  // Mostly rays aimed at the sphere or crossing the plane, with some noise and corners.
  function automatic ray_t random_ray(logic [EpsW-1:0] eps);
    ray_t r;
    int unsigned pick;
    int unsigned sh;
    pick = $urandom_range(0, 9);
    r.kind = kind_e'($urandom_range(0, 1));
    r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
    r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
    if (pick >= 2 && pick <= 5) begin
      r.kind = KIND_SPHERE;
      r.ox = spread(32'h40000); r.oy = spread(32'h40000); r.oz = spread(32'h40000);
      r.dx = spread(32'hC000) - r.ox;
      r.dy = spread(32'hC000) - r.oy;
      r.dz = spread(32'hC000) - r.oz;
      sh = $urandom_range(0, 10);
      r.dx = $signed(r.dx) >>> sh; r.dy = $signed(r.dy) >>> sh; r.dz = $signed(r.dz) >>> sh;
    end else if (pick >= 6 && pick <= 8) begin
      r.kind = KIND_PLANE;
      if ($urandom_range(0, 1)) r.oy = spread(32'h100000);
      case ($urandom_range(0, 3))
        0: r.dy = 32'h0;
        1: r.dy = spread(eps + 2);
        2: r.dy = spread(32'h20000);
        default: r.dy = $urandom;
      endcase
    end else if (pick == 9) begin
      r.ox = corner_value(); r.oy = corner_value(); r.oz = corner_value();
      r.dx = corner_value(); r.dy = corner_value(); r.dz = corner_value();
    end
    return r;
  endfunction

  // Input side: one transaction is presented at a time and held while stalled.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      hits_due.push_back(ray_feed[0].typed ? ray_feed[0].want
                                           : intersect_ray(ray_feed[0].ray, eps_now));
      void'(ray_feed.pop_front());
    end
    if (in_valid_i && in_stall_o) begin
    end else if (ray_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid_i    <= 1'b1;
      object_kind_i <= ray_feed[0].ray.kind;
      origin_x_i    <= ray_feed[0].ray.ox;
      origin_y_i    <= ray_feed[0].ray.oy;
      origin_z_i    <= ray_feed[0].ray.oz;
      dir_x_i       <= ray_feed[0].ray.dx;
      dir_y_i       <= ray_feed[0].ray.dy;
      dir_z_i       <= ray_feed[0].ray.dz;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Output side: compare each result transaction with the oldest one due.
  always @(posedge clk_i) begin
    hit_t want;
    if (out_valid_o && !out_stall_i) begin
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result hits=%0d t1=%h t2=%h", $time, hit_count_o,
                 t_first_o, t_second_o);
        fails++;
      end else begin
        want = hits_due.pop_front();
        if (hit_count_o !== want.hits) begin
          $display("%0t: hit_count expected %0d actual %0d", $time, want.hits, hit_count_o);
          fails++;
        end
        if (t_first_o !== want.t_near) begin
          $display("%0t: t_first expected %h actual %h", $time, want.t_near, t_first_o);
          fails++;
        end
        if (t_second_o !== want.t_far) begin
          $display("%0t: t_second expected %h actual %h", $time, want.t_far, t_second_o);
          fails++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (ray_feed.size() > 0 || hits_due.size() > 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("ray_sphere_plane_intersect_test NOT OK");
        $finish;
      end
    end
  end

  task automatic drain();
    while (ray_feed.size() > 0 || in_valid_i || hits_due.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_eps(logic [EpsW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    eps_now = v;
  endtask

  initial begin
    logic [EpsW-1:0] eps_plan [6];
    row_t row;
    eps_plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd7, 16'($urandom_range(0, 64))};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 32;
    recv_stall_pct = 73;
    foreach (DirTab[i]) ray_feed.push_back(DirTab[i]);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_eps(eps_plan[p]);
      send_idle_pct = (p < 2) ? 32 : (p < 4) ? 73 : 0;
      recv_stall_pct = (p < 2) ? 73 : (p < 4) ? 32 : 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        row.ray = random_ray(eps_now);
        row.typed = 1'b0;
        row.want = '{HITS_NONE, 32'h0, 32'h0};
        ray_feed.push_back(row);
      end
      drain();
    end
    if (fails == 0) begin
      $display("ray_sphere_plane_intersect_test OK");
    end else begin
      $display("ray_sphere_plane_intersect_test NOT OK");
    end
    $finish;
  end

endmodule

### ray_sphere_plane_intersect.f
+incdir+sv
sv/rspi_pkg.sv
sv/ray_sphere_plane_intersect.sv
sim/ray_sphere_plane_intersect_test.sv
